@@ hw/rtl/swl_pkg.sv @@
// Shared types and constants for the stopwatch with lap store.
// Used by swl_core, swl_split and the top level; depends on nothing.
package swl_pkg;

    localparam int TIME_W    = 32;
    localparam int LAPNUM_W  = 16;
    localparam int ROW_W     = 6;
    localparam int OFFSET_W  = 6;
    localparam int VIS_W     = 7;
    localparam int HOURS_W   = 14;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int SUBSEC_W  = 7;

    localparam logic [VIS_W-1:0]    VIS_LINES_RST = 7'd8;
    localparam logic [TIME_W-1:0]   ELAPSED_MAX   = 32'hFFFF_FFFF;
    localparam logic [LAPNUM_W-1:0] LAPCNT_MAX    = 16'hFFFF;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX    = 6'd63;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_START_STOP  = 3'd1,
        OP_RESET       = 3'd2,
        OP_LAP         = 3'd3,
        OP_SCROLL_UP   = 3'd4,
        OP_SCROLL_DOWN = 3'd5,
        OP_READ_ROW    = 3'd6
    } t_op;

    typedef struct packed {
        logic                vld;
        logic                running;
        logic [LAPNUM_W-1:0] lap_number;
        logic                lap_valid;
        logic                split_valid;
        logic [TIME_W-1:0]   total;
        logic [TIME_W-1:0]   split;
    } t_core_res;

endpackage

@@ hw/rtl/stopwatch_with_lap_store_unit.sv @@
// Top level of the stopwatch with lap store.
// Instantiates swl_core and two swl_split pipelines; uses swl_pkg.
//
// Usage: a request (i_op, i_row) is taken at each rising edge with start
// high; busy is always low, so a new request may be issued in every cycle.
// Operations are tick, start/stop, reset, lap, scroll up, scroll down and
// read row. Every request yields exactly one result, shown for one cycle
// with o_done high, in request order.
// Each result passes through the core, which updates the state and reads
// the lap ring, then through three chained constant dividers that split
// totals into hours, minutes, seconds and sub-seconds by reciprocal
// multiplication.
// Throughput: one request per cycle; the receiver cannot stall results.
// The visible line count resets to 8 and is written through i_cfg_we and
// i_cfg_wdata; the user must do so while no request is in flight, and the
// block does not enforce this. A synchronous reset clears the counters,
// the running flag and the scroll offset; the lap ring is not cleared.
module stopwatch_with_lap_store_unit import swl_pkg::*; #(
    parameter int LAP_SLOTS        = 64,
    parameter int TICKS_PER_SECOND = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_op,
    input  logic [ROW_W-1:0]    i_row,
    input  logic                i_cfg_we,
    input  logic [VIS_W-1:0]    i_cfg_wdata,
    output logic                o_done,
    output logic                o_running,
    output logic [LAPNUM_W-1:0] o_lap_number,
    output logic                o_lap_valid,
    output logic                o_split_valid,
    output logic [HOURS_W-1:0]  o_total_hours,
    output logic [MIN_W-1:0]    o_total_minutes,
    output logic [SEC_W-1:0]    o_total_seconds,
    output logic [SUBSEC_W-1:0] o_total_subsec,
    output logic [HOURS_W-1:0]  o_split_hours,
    output logic [MIN_W-1:0]    o_split_minutes,
    output logic [SEC_W-1:0]    o_split_seconds,
    output logic [SUBSEC_W-1:0] o_split_subsec
);

    localparam int TOT_TAG_W = LAPNUM_W + 2;

    t_core_res              core_res;
    logic [TOT_TAG_W-1:0]   tot_tag;
    logic                   tot_vld;
    logic                   lap_vld;

    assign busy = 1'b0;

    swl_core #(
        .LAP_SLOTS (LAP_SLOTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (core_res)
    );

    swl_split #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TAG_W            (TOT_TAG_W)
    ) u_split_total (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (core_res.vld),
        .i_value   (core_res.total),
        .i_tag     ({core_res.running, core_res.lap_number, core_res.lap_valid}),
        .o_vld     (tot_vld),
        .o_hours   (o_total_hours),
        .o_minutes (o_total_minutes),
        .o_seconds (o_total_seconds),
        .o_subsec  (o_total_subsec),
        .o_tag     (tot_tag)
    );

    swl_split #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TAG_W            (1)
    ) u_split_lap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (core_res.vld),
        .i_value   (core_res.split),
        .i_tag     (core_res.split_valid),
        .o_vld     (lap_vld),
        .o_hours   (o_split_hours),
        .o_minutes (o_split_minutes),
        .o_seconds (o_split_seconds),
        .o_subsec  (o_split_subsec),
        .o_tag     (o_split_valid)
    );

    assign o_done       = tot_vld & lap_vld;
    assign o_running    = tot_tag[TOT_TAG_W-1];
    assign o_lap_number = tot_tag[1 +: LAPNUM_W];
    assign o_lap_valid  = tot_tag[0];

endmodule

@@ hw/rtl/swl_cdiv.sv @@
// Pipelined divider by a constant using reciprocal multiplication, two stages.
// Carries a side tag alongside the division; depends on nothing.
module swl_cdiv #(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 3,
    parameter int REM_W   = ($clog2(DIVISOR) > 0) ? $clog2(DIVISOR) : 1,
    parameter int TAG_W   = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [WIDTH-1:0] i_num,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_quo,
    output logic [REM_W-1:0] o_rem,
    output logic [TAG_W-1:0] o_tag
);

    // The rounded-up reciprocal with this shift gives the exact quotient for
    // every numerator of WIDTH bits.
    localparam int                SHIFT   = WIDTH + $clog2(DIVISOR);
    localparam logic [63:0]       RECIP_V = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                            / 64'(DIVISOR);
    localparam logic [WIDTH:0]    RECIP   = RECIP_V[WIDTH:0];
    localparam logic [WIDTH-1:0]  DIV_W   = WIDTH'(DIVISOR);
    localparam int                PROD_W  = 2 * WIDTH + 1;

    logic [PROD_W-1:0] prod, prod_sh;
    logic [WIDTH-1:0]  back_mul, diff;

    logic             r_s1_vld;
    logic [WIDTH-1:0] r_s1_num;
    logic [WIDTH-1:0] r_s1_quo;
    logic [TAG_W-1:0] r_s1_tag;
    logic             r_vld;
    logic [WIDTH-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [TAG_W-1:0] r_tag;

    always_comb begin
        prod     = PROD_W'(i_num) * PROD_W'(RECIP);
        prod_sh  = prod >> SHIFT;
        back_mul = r_s1_quo * DIV_W;
        diff     = r_s1_num - back_mul;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_vld    <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_num <= i_num;
        r_s1_quo <= prod_sh[WIDTH-1:0];
        r_s1_tag <= i_tag;
        r_quo    <= r_s1_quo;
        r_rem    <= diff[REM_W-1:0];
        r_tag    <= r_s1_tag;
    end

    assign o_vld = r_vld;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
    assign o_tag = r_tag;

endmodule

@@ hw/rtl/swl_split.sv @@
// Breaks a tick count into hours, minutes, seconds and sub-second ticks.
// Three chained swl_cdiv pipelines; uses swl_pkg for the field widths.
module swl_split import swl_pkg::*; #(
    parameter int TICKS_PER_SECOND = 100,
    parameter int TAG_W            = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [TIME_W-1:0]   i_value,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_vld,
    output logic [HOURS_W-1:0]  o_hours,
    output logic [MIN_W-1:0]    o_minutes,
    output logic [SEC_W-1:0]    o_seconds,
    output logic [SUBSEC_W-1:0] o_subsec,
    output logic [TAG_W-1:0]    o_tag
);

    localparam int PER_HOUR = TICKS_PER_SECOND * 3600;
    localparam int PER_MIN  = TICKS_PER_SECOND * 60;
    localparam int H_REM_W  = $clog2(PER_HOUR);
    localparam int M_REM_W  = $clog2(PER_MIN);
    localparam int S_REM_W  = ($clog2(TICKS_PER_SECOND) > 0) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int TAG_M_W  = TAG_W + HOURS_W;
    localparam int TAG_S_W  = TAG_M_W + MIN_W;

    logic               vld_h;
    logic [TIME_W-1:0]  quo_h;
    logic [H_REM_W-1:0] rem_h;
    logic [TAG_W-1:0]   tag_h;
    logic               vld_m;
    logic [H_REM_W-1:0] quo_m;
    logic [M_REM_W-1:0] rem_m;
    logic [TAG_M_W-1:0] tag_m;
    logic [M_REM_W-1:0] quo_s;
    logic [S_REM_W-1:0] rem_s;
    logic [TAG_S_W-1:0] tag_s;

    swl_cdiv #(
        .WIDTH   (TIME_W),
        .DIVISOR (PER_HOUR),
        .REM_W   (H_REM_W),
        .TAG_W   (TAG_W)
    ) u_div_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_num   (i_value),
        .i_tag   (i_tag),
        .o_vld   (vld_h),
        .o_quo   (quo_h),
        .o_rem   (rem_h),
        .o_tag   (tag_h)
    );

    swl_cdiv #(
        .WIDTH   (H_REM_W),
        .DIVISOR (PER_MIN),
        .REM_W   (M_REM_W),
        .TAG_W   (TAG_M_W)
    ) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_h),
        .i_num   (rem_h),
        .i_tag   ({tag_h, quo_h[HOURS_W-1:0]}),
        .o_vld   (vld_m),
        .o_quo   (quo_m),
        .o_rem   (rem_m),
        .o_tag   (tag_m)
    );

    swl_cdiv #(
        .WIDTH   (M_REM_W),
        .DIVISOR (TICKS_PER_SECOND),
        .REM_W   (S_REM_W),
        .TAG_W   (TAG_S_W)
    ) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_m),
        .i_num   (rem_m),
        .i_tag   ({tag_m, quo_m[MIN_W-1:0]}),
        .o_vld   (o_vld),
        .o_quo   (quo_s),
        .o_rem   (rem_s),
        .o_tag   (tag_s)
    );

    assign o_seconds = quo_s[SEC_W-1:0];
    assign o_subsec  = SUBSEC_W'(rem_s);
    assign o_minutes = tag_s[MIN_W-1:0];
    assign o_hours   = tag_s[MIN_W +: HOURS_W];
    assign o_tag     = tag_s[TAG_S_W-1 -: TAG_W];

endmodule

@@ hw/rtl/swl_core.sv @@
// Stopwatch state, lap ring memory and result selection ahead of the time split.
// Uses swl_pkg for the operation codes, widths and the result struct.
module swl_core import swl_pkg::*; #(
    parameter int LAP_SLOTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_op,
    input  logic [ROW_W-1:0]   i_row,
    input  logic               i_cfg_we,
    input  logic [VIS_W-1:0]   i_cfg_wdata,
    output t_core_res          o_res
);

    localparam int SW    = $clog2(LAP_SLOTS);
    localparam int MOD_N = 128;
    localparam int DIFF_W = LAPNUM_W + 2;
    localparam int SUM_W  = LAPNUM_W + 1;

    t_op                 op;
    logic [TIME_W-1:0]   r_elapsed, n_elapsed;
    logic                r_running, n_running;
    logic [LAPNUM_W-1:0] r_lap_count, n_lap_count;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [SW-1:0]       r_wr_slot, n_wr_slot;
    logic [VIS_W-1:0]    r_vis_lines;
    logic [TIME_W-1:0]   r_ring [LAP_SLOTS];

    logic [SW-1:0]       mod_tbl [MOD_N];
    logic [SW-1:0]       last_slot, back, rd_cur, rd_prev;
    logic [SW-1:0]       next_slot;
    logic [DIFF_W-1:0]   lap_diff;
    logic                lap_pos, lap_gt1;
    logic [SUM_W-1:0]    off_lines;
    logic                down_ok;

    logic                r_s1_vld;
    logic                r_s1_read, r_s1_lap_pos, r_s1_lap_gt1, r_s1_running;
    logic [LAPNUM_W-1:0] r_s1_lap, r_s1_lap_count;
    logic [TIME_W-1:0]   r_s1_elapsed, r_cur, r_prev;
    t_core_res           r_res, n_res;

    for (genvar i = 0; i < MOD_N; i++) begin : g_mod
        assign mod_tbl[i] = SW'(i % LAP_SLOTS);
    end

    assign op = t_op'(i_op);

    always_comb begin
        off_lines = SUM_W'(r_offset) + SUM_W'(r_vis_lines);
        down_ok   = (off_lines < SUM_W'(r_lap_count)) && (off_lines < SUM_W'(LAP_SLOTS))
                    && (r_offset != OFFSET_MAX);
        next_slot = (r_wr_slot == SW'(LAP_SLOTS - 1)) ? '0 : r_wr_slot + 1'b1;

        n_elapsed   = r_elapsed;
        n_running   = r_running;
        n_lap_count = r_lap_count;
        n_offset    = r_offset;
        n_wr_slot   = r_wr_slot;
        if (i_start) begin
            case (op)
                OP_TICK: begin
                    if (r_running && r_elapsed != ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                end
                OP_START_STOP: begin
                    n_running = !r_running;
                end
                OP_RESET: begin
                    if (!r_running) begin
                        n_elapsed   = '0;
                        n_lap_count = '0;
                        n_wr_slot   = '0;
                    end
                end
                OP_LAP: begin
                    if (r_running) begin
                        if (r_lap_count != LAPCNT_MAX) begin
                            n_lap_count = r_lap_count + 1'b1;
                            n_wr_slot   = next_slot;
                        end
                    end else begin
                        n_running = 1'b1;
                    end
                end
                OP_SCROLL_UP: begin
                    if (r_offset != '0) begin
                        n_offset = r_offset - 1'b1;
                    end
                end
                OP_SCROLL_DOWN: begin
                    if (down_ok) begin
                        n_offset = r_offset + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The write slot always equals the lap count modulo the ring size.
    always_comb begin
        lap_diff  = DIFF_W'(r_lap_count) - DIFF_W'(r_offset) - DIFF_W'(i_row);
        lap_pos   = !lap_diff[DIFF_W-1] && (lap_diff != '0);
        lap_gt1   = !lap_diff[DIFF_W-1] && (lap_diff[DIFF_W-2:1] != '0);
        last_slot = (r_wr_slot == '0) ? SW'(LAP_SLOTS - 1) : r_wr_slot - 1'b1;
        back      = mod_tbl[7'(r_offset) + 7'(i_row)];
        if (last_slot >= back) begin
            rd_cur = last_slot - back;
        end else begin
            rd_cur = SW'((SW+1)'(last_slot) + (SW+1)'(LAP_SLOTS) - (SW+1)'(back));
        end
        rd_prev = (rd_cur == '0) ? SW'(LAP_SLOTS - 1) : rd_cur - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_running   <= 1'b0;
            r_lap_count <= '0;
            r_offset    <= '0;
            r_wr_slot   <= '0;
            r_vis_lines <= VIS_LINES_RST;
            r_s1_vld    <= 1'b0;
            r_res       <= '0;
        end else begin
            r_elapsed   <= n_elapsed;
            r_running   <= n_running;
            r_lap_count <= n_lap_count;
            r_offset    <= n_offset;
            r_wr_slot   <= n_wr_slot;
            if (i_cfg_we) begin
                r_vis_lines <= i_cfg_wdata;
            end
            r_s1_vld    <= i_start;
            r_res       <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && op == OP_LAP && r_running) begin
            r_ring[r_wr_slot] <= r_elapsed;
        end
        r_cur <= r_ring[rd_cur];
        r_prev <= r_ring[rd_prev];
    end

    always_ff @(posedge i_clk) begin
        r_s1_read      <= (op == OP_READ_ROW);
        r_s1_lap_pos   <= lap_pos;
        r_s1_lap_gt1   <= lap_gt1;
        r_s1_lap       <= lap_diff[LAPNUM_W-1:0];
        r_s1_running   <= n_running;
        r_s1_lap_count <= n_lap_count;
        r_s1_elapsed   <= n_elapsed;
    end

    always_comb begin
        n_res         = '0;
        n_res.vld     = r_s1_vld;
        n_res.running = r_s1_running;
        if (r_s1_read) begin
            if (r_s1_lap_pos) begin
                n_res.lap_number = r_s1_lap;
                n_res.lap_valid  = 1'b1;
                n_res.total      = r_cur;
            end
            if (r_s1_lap_gt1) begin
                n_res.split_valid = 1'b1;
                n_res.split       = r_cur - r_prev;
            end
        end else begin
            n_res.lap_number = r_s1_lap_count;
            n_res.total      = r_s1_elapsed;
        end
    end

    assign o_res = r_res;

endmodule

@@ verif/tb.sv @@
// Testbench for stopwatch_with_lap_store_unit: directed and random requests with a
// scoreboard class that tracks the watch state and checks every result in order.
// Depends on swl_pkg and the RTL of the unit only.
module tb import swl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAP_SLOTS          = 64;
    localparam int TICKS_PER_SECOND   = 100;
    localparam int SECONDS_PER_HOUR   = 3600;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int TAIL_CYCLES        = 80;
    localparam int PHASE_ITEMS        = 135;
    localparam logic [2:0] OP_NO_EFFECT = 3'd7;

    typedef struct {
        logic [HOURS_W-1:0]  hours;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [SUBSEC_W-1:0] subsec;
    } watch_time_t;

    typedef struct {
        logic                running;
        logic [LAPNUM_W-1:0] lap_number;
        logic                lap_valid;
        logic                split_valid;
        watch_time_t         total;
        watch_time_t         split;
    } watch_display_t;

    class lap_watch_tracker;
        bit [TIME_W-1:0]   elapsed;
        bit                running;
        bit [LAPNUM_W-1:0] laps;
        bit [OFFSET_W-1:0] offset;
        bit [VIS_W-1:0]    lines;
        bit [TIME_W-1:0]   ring [LAP_SLOTS];
        watch_display_t    pending [$];
        int                errors;

        function new();
            elapsed = '0;
            running = 1'b0;
            laps    = '0;
            offset  = '0;
            lines   = VIS_LINES_RST;
            errors  = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function watch_time_t break_down_time(bit [TIME_W-1:0] t);
            longint unsigned v, h, m, s;
            watch_time_t r;
            v = 64'(t);
            h = v / (TICKS_PER_SECOND * SECONDS_PER_HOUR);
            v = v - h * (TICKS_PER_SECOND * SECONDS_PER_HOUR);
            m = v / (TICKS_PER_SECOND * SECONDS_PER_MINUTE);
            v = v - m * (TICKS_PER_SECOND * SECONDS_PER_MINUTE);
            s = v / TICKS_PER_SECOND;
            v = v - s * TICKS_PER_SECOND;
            r.hours   = HOURS_W'(h);
            r.minutes = MIN_W'(m);
            r.seconds = SEC_W'(s);
            r.subsec  = SUBSEC_W'(v);
            return r;
        endfunction

        function void take_request(logic [2:0] op, logic [ROW_W-1:0] row);
            watch_display_t d;
            int lap_no;
            bit [TIME_W-1:0] cur, prev;
            case (op)
                OP_TICK: begin
                    if (running && elapsed != ELAPSED_MAX) elapsed++;
                end
                OP_START_STOP: begin
                    running = !running;
                end
                OP_RESET: begin
                    if (!running) begin
                        elapsed = '0;
                        laps    = '0;
                    end
                end
                OP_LAP: begin
                    if (running) begin
                        ring[laps % LAP_SLOTS] = elapsed;
                        if (laps != LAPCNT_MAX) laps++;
                    end else begin
                        running = 1'b1;
                    end
                end
                OP_SCROLL_UP: begin
                    if (offset != 0) offset--;
                end
                OP_SCROLL_DOWN: begin
                    if (int'(offset) < int'(laps) - int'(lines) &&
                        int'(offset) < LAP_SLOTS - int'(lines) && offset < OFFSET_MAX)
                        offset++;
                end
                default: ;
            endcase

            d.running     = running;
            d.lap_number  = '0;
            d.lap_valid   = 1'b0;
            d.split_valid = 1'b0;
            d.total       = break_down_time('0);
            d.split       = break_down_time('0);
            if (op == OP_READ_ROW) begin
                lap_no = int'(laps) - int'(offset) - int'(row);
                if (lap_no > 0) begin
                    cur          = ring[(lap_no - 1) % LAP_SLOTS];
                    d.lap_number = LAPNUM_W'(lap_no);
                    d.lap_valid  = 1'b1;
                    d.total      = break_down_time(cur);
                    if (lap_no > 1) begin
                        prev          = ring[(lap_no - 2) % LAP_SLOTS];
                        d.split_valid = 1'b1;
                        d.split       = break_down_time(cur - prev);
                    end
                end
            end else begin
                d.lap_number = laps;
                d.total      = break_down_time(elapsed);
            end
            pending.push_back(d);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_display(watch_display_t got);
            watch_display_t want;
            if (pending.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("running", 32'(want.running), 32'(got.running));
            check_field("lap_number", 32'(want.lap_number), 32'(got.lap_number));
            check_field("lap_valid", 32'(want.lap_valid), 32'(got.lap_valid));
            check_field("split_valid", 32'(want.split_valid), 32'(got.split_valid));
            check_field("total_hours", 32'(want.total.hours), 32'(got.total.hours));
            check_field("total_minutes", 32'(want.total.minutes), 32'(got.total.minutes));
            check_field("total_seconds", 32'(want.total.seconds), 32'(got.total.seconds));
            check_field("total_subsec", 32'(want.total.subsec), 32'(got.total.subsec));
            check_field("split_hours", 32'(want.split.hours), 32'(got.split.hours));
            check_field("split_minutes", 32'(want.split.minutes), 32'(got.split.minutes));
            check_field("split_seconds", 32'(want.split.seconds), 32'(got.split.seconds));
            check_field("split_subsec", 32'(want.split.subsec), 32'(got.split.subsec));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [2:0]          i_op        = '0;
    logic [ROW_W-1:0]    i_row       = '0;
    logic                i_cfg_we    = 1'b0;
    logic [VIS_W-1:0]    i_cfg_wdata = '0;
    logic                o_done;
    logic                o_running;
    logic [LAPNUM_W-1:0] o_lap_number;
    logic                o_lap_valid;
    logic                o_split_valid;
    logic [HOURS_W-1:0]  o_total_hours;
    logic [MIN_W-1:0]    o_total_minutes;
    logic [SEC_W-1:0]    o_total_seconds;
    logic [SUBSEC_W-1:0] o_total_subsec;
    logic [HOURS_W-1:0]  o_split_hours;
    logic [MIN_W-1:0]    o_split_minutes;
    logic [SEC_W-1:0]    o_split_seconds;
    logic [SUBSEC_W-1:0] o_split_subsec;

    lap_watch_tracker board;
    int burst_left;
    int requests_sent;

    stopwatch_with_lap_store_unit #(
        .LAP_SLOTS        (LAP_SLOTS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_row           (i_row),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_running       (o_running),
        .o_lap_number    (o_lap_number),
        .o_lap_valid     (o_lap_valid),
        .o_split_valid   (o_split_valid),
        .o_total_hours   (o_total_hours),
        .o_total_minutes (o_total_minutes),
        .o_total_seconds (o_total_seconds),
        .o_total_subsec  (o_total_subsec),
        .o_split_hours   (o_split_hours),
        .o_split_minutes (o_split_minutes),
        .o_split_seconds (o_split_seconds),
        .o_split_subsec  (o_split_subsec)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        watch_display_t seen;
        if (i_rst_n && o_done) begin
            seen.running       = o_running;
            seen.lap_number    = o_lap_number;
            seen.lap_valid     = o_lap_valid;
            seen.split_valid   = o_split_valid;
            seen.total.hours   = o_total_hours;
            seen.total.minutes = o_total_minutes;
            seen.total.seconds = o_total_seconds;
            seen.total.subsec  = o_total_subsec;
            seen.split.hours   = o_split_hours;
            seen.split.minutes = o_split_minutes;
            seen.split.seconds = o_split_seconds;
            seen.split.subsec  = o_split_subsec;
            board.match_display(seen);
        end
    end

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic issue(logic [2:0] op, logic [ROW_W-1:0] row);
        int gap;
        start <= 1'b1;
        i_op  <= op;
        i_row <= row;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.take_request(op, row);
        requests_sent++;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) hold_off(gap);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_visible_lines(logic [VIS_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.lines = value;
    endtask

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 9) < 7) return ROW_W'($urandom_range(0, 7));
        return ROW_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [2:0] pick_op(int lap_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < lap_weight)      return OP_LAP;
        if (r < lap_weight + 20) return OP_READ_ROW;
        if (r < lap_weight + 28) return OP_SCROLL_DOWN;
        if (r < lap_weight + 33) return OP_SCROLL_UP;
        if (r < lap_weight + 35) return OP_START_STOP;
        if (r < lap_weight + 36) return OP_RESET;
        if (r < lap_weight + 37) return OP_NO_EFFECT;
        return OP_TICK;
    endfunction

    // A session optionally stops and clears the watch, starts it, then runs a mix of requests.
    task automatic run_session(int length, int lap_weight);
        if ($urandom_range(0, 3) == 0) begin
            if (board.running) issue(OP_START_STOP, pick_row());
            issue(OP_RESET, pick_row());
        end
        if (!board.running) issue($urandom_range(0, 1) ? OP_START_STOP : OP_LAP, pick_row());
        repeat (length) issue(pick_op(lap_weight), pick_row());
    endtask

    initial begin
        int target;
        logic [VIS_W-1:0] lines_plan [7];

        board = new();
        burst_left = 0;
        requests_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(OP_READ_ROW, 6'd0);
        issue(OP_NO_EFFECT, 6'd63);
        issue(OP_SCROLL_UP, 6'd0);
        issue(OP_SCROLL_DOWN, 6'd0);
        issue(OP_TICK, 6'd0);
        issue(OP_LAP, 6'd0);
        issue(OP_TICK, 6'd0);
        issue(OP_TICK, 6'd0);
        issue(OP_LAP, 6'd0);
        issue(OP_TICK, 6'd0);
        issue(OP_LAP, 6'd0);
        issue(OP_RESET, 6'd0);
        issue(OP_READ_ROW, 6'd0);
        issue(OP_READ_ROW, 6'd1);
        issue(OP_READ_ROW, 6'd63);
        issue(OP_START_STOP, 6'd42);
        issue(OP_TICK, 6'd21);
        issue(OP_RESET, 6'd0);
        issue(OP_READ_ROW, 6'd0);
        issue(OP_START_STOP, 6'd0);
        issue(OP_SCROLL_DOWN, 6'd0);

        lines_plan = '{7'd1, 7'd64, 7'd0, 7'd127, VIS_LINES_RST, 7'd0, 7'd0};
        for (int p = 0; p < 7; p++) begin
            if (p >= 5) lines_plan[p] = VIS_W'($urandom_range(1, 64));
            wait_quiet();
            write_visible_lines(lines_plan[p]);
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target)
                run_session($urandom_range(20, 120), $urandom_range(10, 55));
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
